>>> rtl/bleadv_pkg.sv
// Shared types and constants for the advertising-data filter and name parser.
// No dependencies.
package bleadv_pkg;

  // Report and name limits
  localparam logic [4:0] MAX_REPORT_BYTES = 5'd31;
  localparam logic [7:0] MAX_NAME_BYTES   = 8'd29;
  localparam logic [4:0] POS_LIMIT        = 5'd31;

  // AD structure type codes
  localparam logic [7:0] AD_FLAGS         = 8'h01;
  localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
  localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

  // Flag bits checked by the discovery filter
  localparam logic [7:0] FLAG_LIMITED     = 8'h01;
  localparam logic [7:0] FLAG_GENERAL     = 8'h02;

  // Result queue
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_ALL     = 2'd0,
    MODE_LIMITED = 2'd1,
    MODE_GENERAL = 2'd2
  } disc_mode_t;

  typedef enum logic [1:0] {
    NAME_NONE = 2'd0,
    NAME_OK   = 2'd1,
    NAME_LONG = 2'd2
  } name_state_t;

  typedef enum logic {
    KIND_NAME    = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   name_byte;
    logic         accepted;
    logic         flags_found;
    logic [7:0]   flags_value;
    logic         name_found;
    logic [4:0]   name_length;
    logic         run_end;
  } result_t;

endpackage

>>> rtl/ble_adv_data_filter_parser_top.sv
// Advertising-data AD structure walker with discovery filter and name streaming.
// Depends on bleadv_pkg (types, AD codes, limits).
//
// The results of an accepted byte are registered into a four-entry result queue.
// Throughput: one byte per cycle while two queue slots are free; a final byte that also
// carries a name byte makes two results, drained one per cycle while out_stall is low.
// Reset (rst, synchronous): discovery_mode = 0, per-report state and queue cleared.
module ble_adv_data_filter_parser_top (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       discovery_mode_valid,
  output logic       discovery_mode_ready,
  input  logic [1:0] discovery_mode,
  // input byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic [4:0] report_length,
  input  logic       last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [7:0] name_byte,
  output logic       accepted,
  output logic       flags_found,
  output logic [7:0] flags_value,
  output logic       name_found,
  output logic [4:0] name_length,
  output logic       run_end
);
  import bleadv_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration and per-report state
  disc_mode_t  mode;
  logic [4:0]  byte_position,      byte_position_next;
  logic [4:0]  next_field_start,   next_field_start_next;
  logic [4:0]  field_end_position, field_end_position_next;
  logic [4:0]  type_pos,           type_pos_next;
  logic        walk_stopped,       walk_stopped_next;
  logic        flags_seen,         flags_seen_next;
  logic [7:0]  flags_store,        flags_store_next;
  name_state_t name_state,         name_state_next;
  logic [4:0]  name_count,         name_count_next;
  logic        flags_done,         flags_done_next;
  logic        flags_pending,      flags_pending_next;
  logic        name_active,        name_active_next;

  // Result queue
  result_t              queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     count, count_next;

  logic       in_xfer, out_xfer;
  logic [4:0] size;
  logic       walk_active;
  logic [8:0] len_sum;
  logic [4:0] field_diff;
  logic       name_emit;
  logic       verdict_acc;
  result_t    name_res, verdict_res, first_res;
  logic [1:0] push_cnt;

  assign discovery_mode_ready = 1'b1;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Hold the mode register; the user must write it only between reports (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ALL;
    end else if (discovery_mode_valid && discovery_mode_ready) begin
      mode <= disc_mode_t'(discovery_mode);
    end
  end

  // Walk the AD structures for the byte at the input
  always_comb begin
    size        = (report_length < MAX_REPORT_BYTES) ? report_length : MAX_REPORT_BYTES;
    walk_active = !walk_stopped && (byte_position < size);
    len_sum     = 9'(byte_position) + 9'd1 + 9'(data_byte);
    field_diff  = field_end_position - type_pos;
    name_emit   = 1'b0;

    byte_position_next      = (byte_position < POS_LIMIT) ? byte_position + 5'd1
                                                          : byte_position;
    next_field_start_next   = next_field_start;
    field_end_position_next = field_end_position;
    type_pos_next           = type_pos;
    walk_stopped_next       = walk_stopped;
    flags_seen_next         = flags_seen;
    flags_store_next        = flags_store;
    name_state_next         = name_state;
    name_count_next         = name_count;
    flags_done_next         = flags_done;
    flags_pending_next      = flags_pending;
    name_active_next        = name_active;

    if (walk_active) begin
      if (byte_position == next_field_start) begin
        // length byte: open the next structure or stop the walk
        name_active_next = 1'b0;
        if (data_byte == 8'd0 || len_sum > 9'(size)) begin
          walk_stopped_next = 1'b1;
        end else begin
          type_pos_next           = byte_position + 5'd1;
          field_end_position_next = byte_position + data_byte[4:0];
          next_field_start_next   = len_sum[4:0];
        end
      end else if (byte_position == type_pos) begin
        // type byte: arm flags capture and name streaming
        if (data_byte == AD_FLAGS && !flags_done) begin
          flags_done_next    = 1'b1;
          flags_pending_next = (field_diff != 5'd0);
        end
        if ((data_byte == AD_NAME_SHORT || data_byte == AD_NAME_COMPLETE) &&
            name_state == NAME_NONE) begin
          if (8'(field_diff) > MAX_NAME_BYTES) begin
            name_state_next = NAME_LONG;
          end else begin
            name_state_next  = NAME_OK;
            name_active_next = 1'b1;
          end
        end
      end else if (byte_position <= field_end_position) begin
        // value byte: capture flags, stream name
        if (flags_pending && byte_position == type_pos + 5'd1) begin
          flags_store_next   = data_byte;
          flags_seen_next    = 1'b1;
          flags_pending_next = 1'b0;
        end
        if (name_active) begin
          if (name_count != POS_LIMIT) begin
            name_count_next = name_count + 5'd1;
          end
          name_emit = 1'b1;
        end
      end
    end

    // Discovery filter verdict on the updated flags
    unique case (mode)
      MODE_ALL:     verdict_acc = 1'b1;
      MODE_LIMITED: verdict_acc = flags_seen_next &&
                                  ((flags_store_next & FLAG_LIMITED) != 8'd0);
      MODE_GENERAL: verdict_acc = flags_seen_next &&
                                  ((flags_store_next & (FLAG_LIMITED | FLAG_GENERAL)) != 8'd0);
      default:      verdict_acc = 1'b0;
    endcase

    name_res             = '0;
    name_res.kind        = KIND_NAME;
    name_res.name_byte   = data_byte;
    name_res.run_end     = !last_byte;

    verdict_res             = '0;
    verdict_res.kind        = KIND_VERDICT;
    verdict_res.accepted    = verdict_acc;
    verdict_res.flags_found = flags_seen_next;
    verdict_res.flags_value = flags_seen_next ? flags_store_next : 8'd0;
    verdict_res.name_found  = (name_state_next == NAME_OK);
    verdict_res.name_length = name_count_next;
    verdict_res.run_end     = 1'b1;

    first_res = name_emit ? name_res : verdict_res;
    push_cnt  = in_xfer ? (2'(name_emit) + 2'(last_byte)) : 2'd0;
  end

  // Advance per-report state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst || (in_xfer && last_byte)) begin
      byte_position      <= '0;
      next_field_start   <= '0;
      field_end_position <= '0;
      type_pos           <= '0;
      walk_stopped       <= 1'b0;
      flags_seen         <= 1'b0;
      flags_store        <= '0;
      name_state         <= NAME_NONE;
      name_count         <= '0;
      flags_done         <= 1'b0;
      flags_pending      <= 1'b0;
      name_active        <= 1'b0;
    end else if (in_xfer) begin
      byte_position      <= byte_position_next;
      next_field_start   <= next_field_start_next;
      field_end_position <= field_end_position_next;
      type_pos           <= type_pos_next;
      walk_stopped       <= walk_stopped_next;
      flags_seen         <= flags_seen_next;
      flags_store        <= flags_store_next;
      name_state         <= name_state_next;
      name_count         <= name_count_next;
      flags_done         <= flags_done_next;
      flags_pending      <= flags_pending_next;
      name_active        <= name_active_next;
    end
  end

  // Stall input unless two result slots are free
  assign in_stall = (count > CNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    count_next = count + CNT_W'(push_cnt) - CNT_W'(out_xfer);
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      if (out_xfer) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Write up to two results per transfer
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push_cnt != 2'd0 && PTR_W'(i) == wr_ptr) begin
        queue[i] <= first_res;
      end else if (push_cnt == 2'd2 && PTR_W'(i) == wr_ptr + PTR_W'(1)) begin
        queue[i] <= verdict_res;
      end
    end
  end

  // Drive the head of the queue
  assign out_valid   = (count != '0);
  assign result_kind = queue[rd_ptr].kind;
  assign name_byte   = queue[rd_ptr].name_byte;
  assign accepted    = queue[rd_ptr].accepted;
  assign flags_found = queue[rd_ptr].flags_found;
  assign flags_value = queue[rd_ptr].flags_value;
  assign name_found  = queue[rd_ptr].name_found;
  assign name_length = queue[rd_ptr].name_length;
  assign run_end     = queue[rd_ptr].run_end;

endmodule

>>> sim/tb_ble_adv_data_filter_parser_top.sv
// Self-checking testbench for the advertising-data AD structure walker:
// it predicts name bytes and discovery verdicts per input byte and compares.
// Depends on bleadv_pkg and rtl/ble_adv_data_filter_parser_top.sv.
module tb_ble_adv_data_filter_parser_top;
  import bleadv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 150;
  // Mode code outside the defined set; the filter rejects every report
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  typedef logic [7:0] byte_list_t[$];

  typedef struct {
    logic [7:0] data;
    logic [4:0] rl;
    logic       last;
  } ad_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       discovery_mode_valid = 1'b0;
  logic       discovery_mode_ready;
  logic [1:0] discovery_mode = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'd0;
  logic [4:0] report_length = 5'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       result_kind;
  logic [7:0] name_byte;
  logic       accepted;
  logic       flags_found;
  logic [7:0] flags_value;
  logic       name_found;
  logic [4:0] name_length;
  logic       run_end;

  ble_adv_data_filter_parser_top uut (
    .clk                 (clk),
    .rst                 (rst),
    .discovery_mode_valid(discovery_mode_valid),
    .discovery_mode_ready(discovery_mode_ready),
    .discovery_mode      (discovery_mode),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .data_byte           (data_byte),
    .report_length       (report_length),
    .last_byte           (last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .result_kind         (result_kind),
    .name_byte           (name_byte),
    .accepted            (accepted),
    .flags_found         (flags_found),
    .flags_value         (flags_value),
    .name_found          (name_found),
    .name_length         (name_length),
    .run_end             (run_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus and expectations
  ad_byte_t byte_feed[$];
  result_t  want_results[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       in_taken = 1'b0;

  // Sender burst and receiver stall controls, set per phase
  int gap_max = 2;
  int stall_pct = 30;
  int burst_left = 8;
  int gap_left = 0;
  int stall_run = 0;
  bit stall_hold = 1'b0;

  // Predicted block state
  logic [1:0]  mode_reg = MODE_ALL;
  logic [4:0]  pos = '0;
  logic [8:0]  next_start = '0;
  logic [8:0]  type_at = '0;
  logic [8:0]  field_end = '0;
  logic [7:0]  field_type = '0;
  logic        walk_done = 1'b0;
  logic        flags_have = 1'b0;
  logic [7:0]  flags_val = '0;
  logic        flags_searched = 1'b0;
  logic        flags_wait = 1'b0;
  name_state_t name_st = NAME_NONE;
  logic        name_live = 1'b0;
  logic [4:0]  name_cnt = '0;

  // Advance the AD walk by one byte and queue the results it produces
  task automatic walk_ad_byte(input logic [7:0] d, input logic [4:0] rl, input logic last);
    logic [4:0] size;
    logic [8:0] p9;
    logic [8:0] flen;
    logic       acc;
    result_t    r;
    size = (rl < MAX_REPORT_BYTES) ? rl : MAX_REPORT_BYTES;
    p9 = {4'd0, pos};
    if (!walk_done && pos < size) begin
      if (p9 == next_start) begin
        // length byte: stop on zero or on a structure that overruns the report
        name_live = 1'b0;
        if (d == 8'd0 || p9 + 9'd1 + {1'b0, d} > {4'd0, size}) begin
          walk_done = 1'b1;
        end else begin
          type_at = p9 + 9'd1;
          field_end = p9 + {1'b0, d};
          next_start = p9 + 9'd1 + {1'b0, d};
        end
      end else if (p9 == type_at) begin
        flen = field_end - type_at + 9'd1;
        field_type = d;
        if (d == AD_FLAGS && !flags_searched) begin
          flags_searched = 1'b1;
          flags_wait = (flen >= 9'd2);
        end
        if ((d == AD_NAME_SHORT || d == AD_NAME_COMPLETE) && name_st == NAME_NONE) begin
          if (flen - 9'd1 > {1'b0, MAX_NAME_BYTES}) begin
            name_st = NAME_LONG;
          end else begin
            name_st = NAME_OK;
            name_live = 1'b1;
          end
        end
      end else if (p9 <= field_end) begin
        if (flags_wait && p9 == type_at + 9'd1) begin
          flags_val = d;
          flags_have = 1'b1;
          flags_wait = 1'b0;
        end
        if (name_live) begin
          if (name_cnt < POS_LIMIT) name_cnt++;
          r = '0;
          r.kind = KIND_NAME;
          r.name_byte = d;
          r.run_end = !last;
          want_results.push_back(r);
        end
      end
    end
    if (pos < POS_LIMIT) pos++;

    // final byte: give the verdict and clear the per-report state
    if (last) begin
      case (mode_reg)
        MODE_ALL:     acc = 1'b1;
        MODE_LIMITED: acc = flags_have && ((flags_val & FLAG_LIMITED) != 8'd0);
        MODE_GENERAL: acc = flags_have && ((flags_val & (FLAG_LIMITED | FLAG_GENERAL)) != 8'd0);
        default:      acc = 1'b0;
      endcase
      r = '0;
      r.kind = KIND_VERDICT;
      r.accepted = acc;
      r.flags_found = flags_have;
      r.flags_value = flags_have ? flags_val : 8'd0;
      r.name_found = (name_st == NAME_OK);
      r.name_length = name_cnt;
      r.run_end = 1'b1;
      want_results.push_back(r);
      pos = '0;
      next_start = '0;
      type_at = '0;
      field_end = '0;
      field_type = '0;
      walk_done = 1'b0;
      flags_have = 1'b0;
      flags_val = '0;
      flags_searched = 1'b0;
      flags_wait = 1'b0;
      name_st = NAME_NONE;
      name_live = 1'b0;
      name_cnt = '0;
    end
  endtask

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatch_count++;
    end
  endtask

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[ble_adv_data_filter_parser_top] ERROR");
      $finish;
    end
  end

  // Monitor: track config writes, predict accepted bytes, check result transfers
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (discovery_mode_valid && discovery_mode_ready) mode_reg = discovery_mode;
      if (in_taken) walk_ad_byte(data_byte, report_length, last_byte);
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          $error("result_kind: expected nothing, got %0d", result_kind);
          mismatch_count++;
        end else begin
          want = want_results.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(result_kind));
          check_field("name_byte", want.name_byte, name_byte);
          check_field("accepted", 8'(want.accepted), 8'(accepted));
          check_field("flags_found", 8'(want.flags_found), 8'(flags_found));
          check_field("flags_value", want.flags_value, flags_value);
          check_field("name_found", 8'(want.name_found), 8'(name_found));
          check_field("name_length", 8'(want.name_length), 8'(name_length));
          check_field("run_end", 8'(want.run_end), 8'(run_end));
        end
      end
    end
  end

  // Driver: hold the payload until its transfer, send in bursts with gaps
  always @(negedge clk) begin
    ad_byte_t b;
    if (!rst && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_feed.size() > 0) begin
        b = byte_feed.pop_front();
        in_valid <= 1'b1;
        data_byte <= b.data;
        report_length <= b.rl;
        last_byte <= b.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall in runs of random length
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_run = $urandom_range(0, 7);
      stall_hold = ($urandom_range(0, 99) < stall_pct);
    end
    out_stall <= stall_hold;
  end

  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    discovery_mode_valid <= 1'b1;
    discovery_mode <= m;
    @(posedge clk);
    while (!discovery_mode_ready) @(posedge clk);
    @(negedge clk);
    discovery_mode_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every byte is sent and every result has come, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    while (byte_feed.size() != 0 || in_valid || want_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_report(input byte_list_t seq, input logic [4:0] rl);
    ad_byte_t b;
    foreach (seq[i]) begin
      b.data = seq[i];
      b.rl = rl;
      b.last = (i == seq.size() - 1);
      byte_feed.push_back(b);
    end
  endtask

  // Well-formed report with random structures, sometimes broken or mislabeled
  task automatic queue_report();
    byte_list_t ad;
    int room;
    int len;
    int rl;
    int nsend;
    room = $urandom_range(1, 31);
    while (ad.size() < room) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = ($urandom_range(0, 5) == 0) ? 1 : 2;
          ad.push_back(8'(len));
          ad.push_back(AD_FLAGS);
          if (len == 2) ad.push_back(8'($urandom_range(0, 255)));
        end
        2, 3, 4: begin
          len = $urandom_range(1, 12);
          ad.push_back(8'(len));
          ad.push_back($urandom_range(0, 1) ? AD_NAME_SHORT : AD_NAME_COMPLETE);
          repeat (len - 1) ad.push_back(8'($urandom_range(0, 255)));
        end
        9: begin
          // terminator or a length that runs past the report
          ad.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(20, 255)));
        end
        default: begin
          len = $urandom_range(1, 8);
          ad.push_back(8'(len));
          ad.push_back(8'($urandom_range(0, 255)));
          repeat (len - 1) ad.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    while (ad.size() > 31) void'(ad.pop_back());
    rl = ad.size();
    nsend = ad.size();
    case ($urandom_range(0, 9))
      0: rl = $urandom_range(0, 31);
      1: nsend = $urandom_range(1, ad.size());
      2: begin
        // trailing bytes past the report end
        len = $urandom_range(1, 36 - ad.size());
        repeat (len) ad.push_back(8'($urandom_range(0, 255)));
        nsend = ad.size();
      end
      default: ;
    endcase
    while (ad.size() > nsend) void'(ad.pop_back());
    push_report(ad, 5'(rl));
  endtask

  // Raw random bytes, with a length that may change from byte to byte
  task automatic queue_noise();
    ad_byte_t b;
    int nsend;
    bit vary;
    nsend = $urandom_range(1, 36);
    vary = $urandom_range(0, 1);
    b.rl = 5'($urandom_range(0, 31));
    for (int i = 0; i < nsend; i++) begin
      b.data = 8'($urandom_range(0, 255));
      if (vary) b.rl = 5'($urandom_range(0, 31));
      b.last = (i == nsend - 1);
      byte_feed.push_back(b);
    end
  endtask

  // Longest name that fits, then bytes past the end to saturate the position
  task automatic queue_full_name();
    byte_list_t ad;
    ad.push_back(8'd30);
    ad.push_back($urandom_range(0, 1) ? AD_NAME_SHORT : AD_NAME_COMPLETE);
    repeat (34) ad.push_back(8'($urandom_range(0, 255)));
    push_report(ad, 5'd31);
  endtask

  initial begin
    byte_list_t seq;
    logic [1:0] phase_mode[PHASES];
    int phase_gap[PHASES];
    int phase_stall[PHASES];
    phase_mode = '{MODE_LIMITED, MODE_ALL, MODE_UNKNOWN, MODE_GENERAL,
                   MODE_LIMITED, MODE_UNKNOWN, MODE_ALL, MODE_GENERAL};
    phase_gap = '{3, 0, 6, 2, 0, 4, 1, 5};
    phase_stall = '{30, 0, 50, 10, 70, 0, 40, 20};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reports under general discovery
    write_mode(MODE_GENERAL);
    // empty report, verdict only
    seq = '{8'hFF};
    push_report(seq, 5'd0);
    // flags then an empty name
    seq = '{8'h02, AD_FLAGS, 8'h05, 8'h01, AD_NAME_COMPLETE};
    push_report(seq, 5'd5);
    // empty flags ends the flags search; a later flags structure is ignored
    seq = '{8'h01, AD_FLAGS, 8'h02, AD_FLAGS, 8'h03, 8'h03, AD_NAME_SHORT, 8'h00, 8'hFF};
    push_report(seq, 5'd9);
    // zero length stops the walk
    seq = '{8'h00, 8'h02, AD_FLAGS, 8'h07};
    push_report(seq, 5'd4);
    // structure overruns the report
    seq = '{8'h05, AD_NAME_COMPLETE, 8'h41};
    push_report(seq, 5'd3);
    // final byte arrives early and cuts the name; name byte then verdict
    seq = '{8'h04, AD_NAME_COMPLETE, 8'h78, 8'h79};
    push_report(seq, 5'd31);
    wait_idle();

    // Random phases across modes and idling patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(phase_mode[ph]);
      gap_max = phase_gap[ph];
      stall_pct = phase_stall[ph];
      queue_full_name();
      while (byte_feed.size() < PHASE_BYTES) begin
        if ($urandom_range(0, 4) == 0) queue_noise();
        else queue_report();
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("[ble_adv_data_filter_parser_top] OK");
    end else begin
      $display("[ble_adv_data_filter_parser_top] ERROR");
    end
    $finish;
  end

endmodule
